// File: rtl/lmlt_pkg.sv
// Shared types and timing constants for the LCD mode and line timing block.
package lmlt_pkg;

	localparam int unsigned VISIBLE_LINES = 144;
	localparam int unsigned TOTAL_LINES   = VISIBLE_LINES + 10;

	localparam logic [9:0] SEARCH_TICKS = 10'd80;
	localparam logic [9:0] XFER_TICKS   = 10'd172;
	localparam logic [9:0] HBL_PERIOD   = 10'd204;
	localparam logic [9:0] LINE_TICKS   = SEARCH_TICKS + XFER_TICKS + HBL_PERIOD;

	localparam logic [7:0] LAST_VISIBLE = 8'(VISIBLE_LINES);
	localparam logic [8:0] LINE_WRAP    = 9'(TOTAL_LINES);

	// configuration register indexes
	localparam logic [1:0] REG_LINE_COMPARE   = 2'd0;
	localparam logic [1:0] REG_COMPARE_IRQ_EN = 2'd1;
	localparam logic [1:0] REG_VBLANK_IRQ_EN  = 2'd2;
	localparam logic [1:0] REG_SEARCH_IRQ_EN  = 2'd3;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] line_compare;
		logic       compare_irq_enable;
		logic       vblank_stat_irq_enable;
		logic       search_irq_enable;
	} cfg_t;

	// first field in the highest bits
	typedef struct packed {
		logic       render_line;
		logic       stat_irq;
		logic       vblank_irq;
		logic       coincidence;
		logic [7:0] line;
		mode_t      mode;
	} result_t;

endpackage

// File: rtl/lmlt_timer.sv
// Mode, line and tick counter state with its single-step update logic.
module lmlt_timer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [5:0]       elapsed_clocks,
	input  lmlt_pkg::cfg_t   cfg,
	output lmlt_pkg::result_t result
);
	import lmlt_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] line_q, line_d;
	logic [9:0] tick_q, tick_d;
	logic       coincide_q, coincide_d;

	logic [9:0] tick_sum;
	logic [8:0] line_inc;
	logic       line_change;
	logic       vbl, stat, render;

	assign tick_sum = tick_q + {4'b0, elapsed_clocks};
	assign line_inc = {1'b0, line_q} + 9'd1;

	// next state
	always_comb begin
		mode_d      = mode_q;
		line_d      = line_q;
		tick_d      = tick_sum;
		line_change = 1'b0;
		unique case (mode_q)
			MODE_SEARCH: begin
				if (tick_sum >= SEARCH_TICKS) begin
					tick_d = tick_sum - SEARCH_TICKS;
					mode_d = MODE_XFER;
				end
			end
			MODE_XFER: begin
				if (tick_sum >= XFER_TICKS) begin
					tick_d = tick_sum - XFER_TICKS;
					mode_d = MODE_HBLANK;
				end
			end
			MODE_HBLANK: begin
				if (tick_sum >= HBL_PERIOD) begin
					tick_d      = tick_sum - HBL_PERIOD;
					line_d      = line_inc[7:0];
					line_change = 1'b1;
					mode_d      = (line_inc[7:0] == LAST_VISIBLE) ? MODE_VBLANK : MODE_SEARCH;
				end
			end
			default: begin
				if (tick_sum >= LINE_TICKS) begin
					tick_d      = tick_sum - LINE_TICKS;
					line_d      = (line_inc >= LINE_WRAP) ? 8'd0 : line_inc[7:0];
					line_change = 1'b1;
					if (line_d == 8'd0) mode_d = MODE_SEARCH;
				end
			end
		endcase
		coincide_d = line_change ? (line_d == cfg.line_compare) : coincide_q;
	end

	// pulses
	always_comb begin
		render = (mode_q == MODE_XFER) && (mode_d == MODE_HBLANK);
		vbl    = (mode_q == MODE_HBLANK) && (mode_d == MODE_VBLANK);
		stat   = (line_change && coincide_d && cfg.compare_irq_enable)
		      || (vbl && cfg.vblank_stat_irq_enable)
		      || ((mode_q != MODE_SEARCH) && (mode_d == MODE_SEARCH) && cfg.search_irq_enable);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HBLANK;
			line_q     <= 8'd0;
			tick_q     <= 10'd0;
			coincide_q <= 1'b0;
		end else if (step_en) begin
			mode_q     <= mode_d;
			line_q     <= line_d;
			tick_q     <= tick_d;
			coincide_q <= coincide_d;
		end
	end

	assign result = '{render_line: render, stat_irq: stat, vblank_irq: vbl,
	                  coincidence: coincide_d, line: line_d, mode: mode_d};

endmodule

// File: rtl/lcd_mode_line_timing_core.sv
// LCD mode and line timing: top level with input stage, result register and config.
// An accepted input is held in the input stage until the result register takes it.
// One item per cycle unless the output stalls; the timer's tick add, threshold compare
// and mode update run in the single stage between the input and result registers.
// Reset (arst_n low, asynchronous): hblank on line 0, ticks and flags cleared,
// config registers cleared, both stages empty.
module lcd_mode_line_timing_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [5:0] elapsed_clocks, [7:6] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [1:0] mode, [9:2] line, [10] coincidence,
	                                   // [11] vblank_irq, [12] stat_irq, [13] render_line
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import lmlt_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [5:0] elapsed_s1;
	logic       valid_s2;
	result_t    result_s2;
	result_t    result;
	logic       advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_COMPARE:   cfg_q.line_compare           <= cfg_data;
				REG_COMPARE_IRQ_EN: cfg_q.compare_irq_enable     <= cfg_data[0];
				REG_VBLANK_IRQ_EN:  cfg_q.vblank_stat_irq_enable <= cfg_data[0];
				REG_SEARCH_IRQ_EN:  cfg_q.search_irq_enable      <= cfg_data[0];
				default:            cfg_q                        <= cfg_q;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) elapsed_s1 <= s_axis_tdata[5:0];
	end

	lmlt_timer u_timer (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (advance),
		.elapsed_clocks (elapsed_s1),
		.cfg            (cfg_q),
		.result         (result)
	);

	// result stage: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) result_s2 <= result;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, result_s2};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(elapsed_s1))
		else $error("input stage lost or changed a pending item");

	a_vbl_entry: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.vblank_irq |->
		result_s2.mode == MODE_VBLANK && result_s2.line == LAST_VISIBLE)
		else $error("vblank pulse without vblank entry");

	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.render_line |->
		result_s2.mode == MODE_HBLANK && !result_s2.vblank_irq)
		else $error("render pulse outside transfer end");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> {1'b0, result_s2.line} < LINE_WRAP)
		else $error("line beyond total line count");

endmodule
